FILE: rtl/core/arqst_pkg.sv
`default_nettype none

package arqst_pkg;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_PUT = 2'd0;
  localparam logic [1:0] FUNC_ACK = 2'd1;
  localparam logic [1:0] FUNC_RTX = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_STORED = 3'd0;
  localparam logic [2:0] ST_KEPT   = 3'd1;
  localparam logic [2:0] ST_FREED  = 3'd2;
  localparam logic [2:0] ST_MISS   = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam int unsigned SEQ_W   = 8;
  localparam int unsigned MAP_DEP = 256;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  seq_num;
    logic [10:0] payload_length;
    logic [7:0]  chunk_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [10:0] out_length;
    logic        resend;
    logic        drop_link;
    logic [5:0]  pending_count;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // input transfer: capture item, read the sequence map
    logic slot_rd;  // read the slot record that the map points at
    logic commit;   // update the table and load the result register
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/arqst_ctrl.sv
`default_nettype none

module arqst_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output arqst_pkg::cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SLOT = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = in_valid && (state_r == S_IDLE);
    cmd.slot_rd = (state_r == S_SLOT);
    // The result register must be empty, or emptying now, before a commit.
    cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_SLOT;
      end
      S_SLOT: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_to_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SLOT))
    else $error("accepted item did not move on to the slot read");

  a_commit_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && state_r == S_IDLE))
    else $error("commit did not present a result and return to idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && !cmd.commit) |=> (state_r == S_EXEC && out_valid_r))
    else $error("blocked commit left the execute state");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/arqst_dp.sv
`default_nettype none

module arqst_dp #(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire arqst_pkg::cmd_t  cmd,
  input  wire arqst_pkg::in_t   in_data,
  output arqst_pkg::out_t       out_data
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned SQ_W  = arqst_pkg::SEQ_W;

  // Captured item.
  arqst_pkg::in_t in_r;

  // Sequence map: index memory plus one valid flop per entry.
  logic [IDX_W-1:0] map_mem [arqst_pkg::MAP_DEP];
  logic [arqst_pkg::MAP_DEP-1:0] map_vld_r;
  logic [IDX_W-1:0] map_idx_r;
  logic             map_hit_r;

  // Slot records.
  logic [SQ_W-1:0]  seq_mem [SLOTS];
  logic [10:0]      len_mem [SLOTS];
  logic [7:0]       chk_mem [SLOTS];
  logic [SQ_W-1:0]  seq_rd_r;
  logic [10:0]      len_rd_r;
  logic [7:0]       chk_rd_r;

  logic [SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  arqst_pkg::out_t out_r, res;

  // Execute-stage signals.
  logic             hit;
  logic [SLOTS-1:0] free_vec;
  logic             found;
  logic [IDX_W-1:0] free_idx;
  logic [7:0]       chk_dec;
  logic [10:0]      len_sat;
  logic             map_we, map_wvld;
  logic [IDX_W-1:0] map_widx;
  logic             slot_we;
  logic [IDX_W-1:0] slot_widx;
  logic [SQ_W-1:0]  slot_wseq;
  logic [10:0]      slot_wlen;
  logic [7:0]       slot_wchk;

  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r      <= in_data;
      map_idx_r <= map_mem[in_data.seq_num];
      map_hit_r <= map_vld_r[in_data.seq_num];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_rd) begin
      seq_rd_r <= seq_mem[map_idx_r];
      len_rd_r <= len_mem[map_idx_r];
      chk_rd_r <= chk_mem[map_idx_r];
    end
  end

  // A map entry only counts if it points at a live slot holding this key.
  assign hit = map_hit_r && slot_vld_r[map_idx_r] && (seq_rd_r == in_r.seq_num);

  always_comb begin
    free_vec = ~slot_vld_r;
    if (in_r.func == arqst_pkg::FUNC_PUT && hit) free_vec[map_idx_r] = 1'b1;
  end

  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found    = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign chk_dec = (chk_rd_r != 8'd0) ? (chk_rd_r - 8'd1) : 8'd0;
  assign len_sat = (32'(in_r.payload_length) > 32'(MAX_LEN)) ? 11'(MAX_LEN)
                                                              : in_r.payload_length;

  always_comb begin
    slot_vld_nxt = slot_vld_r;
    cnt_nxt      = cnt_r;
    map_we       = 1'b0;
    map_wvld     = 1'b0;
    map_widx     = free_idx;
    slot_we      = 1'b0;
    slot_widx    = free_idx;
    slot_wseq    = in_r.seq_num;
    slot_wlen    = len_sat;
    slot_wchk    = in_r.chunk_count;
    res          = '0;
    res.status   = arqst_pkg::ST_MISS;

    case (in_r.func)
      arqst_pkg::FUNC_PUT: begin
        if (hit) begin
          slot_vld_nxt[map_idx_r] = 1'b0;
          map_we                  = 1'b1;
        end
        if (found) begin
          slot_vld_nxt[free_idx] = 1'b1;
          slot_we                = 1'b1;
          map_we                 = 1'b1;
          map_wvld               = 1'b1;
          res.status             = arqst_pkg::ST_STORED;
          res.slot_index         = 5'(free_idx);
        end else begin
          res.status = arqst_pkg::ST_FULL;
        end
        cnt_nxt = cnt_r - CNT_W'(hit) + CNT_W'(found);
      end
      arqst_pkg::FUNC_ACK: begin
        if (hit) begin
          res.slot_index = 5'(map_idx_r);
          if (chk_dec == 8'd0) begin
            slot_vld_nxt[map_idx_r] = 1'b0;
            map_we                  = 1'b1;
            cnt_nxt                 = cnt_r - CNT_W'(1);
            res.status              = arqst_pkg::ST_FREED;
          end else begin
            // Rewrite the record with only the chunk count changed.
            slot_we    = 1'b1;
            slot_widx  = map_idx_r;
            slot_wseq  = seq_rd_r;
            slot_wlen  = len_rd_r;
            slot_wchk  = chk_dec;
            res.status = arqst_pkg::ST_KEPT;
          end
        end
      end
      arqst_pkg::FUNC_RTX: begin
        if (hit) begin
          slot_vld_nxt[map_idx_r] = 1'b0;
          map_we                  = 1'b1;
          cnt_nxt                 = cnt_r - CNT_W'(1);
          res.status              = arqst_pkg::ST_FREED;
          res.slot_index          = 5'(map_idx_r);
          res.out_length          = len_rd_r;
          res.resend              = (len_rd_r != 11'd0);
        end else begin
          res.drop_link = 1'b1;
        end
      end
      default: begin
        res.status = arqst_pkg::ST_MISS;
      end
    endcase

    res.pending_count = 6'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && map_we) begin
      map_mem[in_r.seq_num] <= map_widx;
    end
    if (cmd.commit && slot_we) begin
      seq_mem[slot_widx] <= slot_wseq;
      len_mem[slot_widx] <= slot_wlen;
      chk_mem[slot_widx] <= slot_wchk;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r  <= '0;
      slot_vld_r <= '0;
      cnt_r      <= '0;
    end else if (cmd.commit) begin
      if (map_we) map_vld_r[in_r.seq_num] <= map_wvld;
      slot_vld_r <= slot_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(slot_vld_r)))
    else $error("occupancy count disagrees with the slot valid bits");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && in_r.func == arqst_pkg::FUNC_PUT && !found) |-> (cnt_r == CNT_W'(SLOTS)))
    else $error("table reported full with a slot free");

  a_commit_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && slot_we) |-> slot_vld_nxt[slot_widx])
    else $error("slot record written into a slot left free");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/arq_retransmit_slot_table.sv
// Channel  Ports                            Carries
// -------  -------------------------------  --------------------------------------
// input    in_valid, in_ready, in_data      one put, ack or retransmit request
// result   out_valid, out_ready, out_data   status, slot, length and occupancy
//
// The sequence map is read at the input transfer edge, the slot record in the
// slot-read state, and the table is updated and the result loaded when the
// execute state commits; a new item is taken only once the last has committed.
// Reset clears the map and slot valid bits and the occupancy count at once.
// A waiting result does not block the next transfer in; the update stage
// holds only while the result register is still full and not being taken.
`default_nettype none

module arq_retransmit_slot_table #(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire arqst_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output arqst_pkg::out_t       out_data
);

  arqst_pkg::cmd_t cmd;

  arqst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  arqst_dp #(
    .SLOTS   (SLOTS),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
